FILE: rtl/bsss_pkg.sv
package bsss_pkg;

    localparam int COORD_BITS      = 16;
    localparam int PLANES_PER_AXIS = 16;
    localparam int NUM_AXES        = 3;
    localparam int NPLANES         = NUM_AXES * PLANES_PER_AXIS;
    localparam int IDX_BITS        = $clog2(NPLANES);
    localparam int AXIS_BITS       = 2;
    localparam int PLANE_BITS      = $clog2(PLANES_PER_AXIS);
    localparam int CNT_BITS        = 16;
    localparam int MAX_FACES       = 65535;
    localparam int EXT_BITS        = COORD_BITS;
    localparam int PROD_BITS       = 2 * EXT_BITS;
    localparam int SA_BITS         = PROD_BITS + 3;
    localparam int TERM_BITS       = SA_BITS + CNT_BITS;
    localparam int SCORE_BITS      = TERM_BITS + 1;
    localparam int LHS_BITS        = COORD_BITS + 1 + $clog2(PLANES_PER_AXIS + 2);
    localparam int DRAIN_LAST      = NPLANES + 3;
    localparam int DRAIN_BITS      = $clog2(DRAIN_LAST + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [CNT_BITS-1:0] count_t;
    typedef logic [IDX_BITS-1:0] plane_idx_t;

    localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam count_t COUNT_MAX = CNT_BITS'(MAX_FACES);

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec3_t;

    typedef struct packed {
        vec3_t lo;
        vec3_t hi;
    } box_t;

    typedef struct packed {
        count_t count;
        box_t   inner;
        box_t   outer;
    } cell_t;

    typedef struct packed {
        logic upd;
        logic eof;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic       found;
        plane_idx_t idx;
        count_t     count;
    } best_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_FIN
    } state_t;

    localparam box_t BOX_RESET = '{lo: '{x: CMAX, y: CMAX, z: CMAX},
                                   hi: '{x: CMIN, y: CMIN, z: CMIN}};
    localparam cell_t CELL_RESET = '{count: '0, inner: BOX_RESET, outer: BOX_RESET};

endpackage

FILE: rtl/bsss_item_if.sv
interface bsss_item_if;
    logic                    valid;
    logic                    ready;
    logic                    op;
    bsss_pkg::coord_t        center_x;
    bsss_pkg::coord_t        center_y;
    bsss_pkg::coord_t        center_z;
    bsss_pkg::coord_t        vertex_x;
    bsss_pkg::coord_t        vertex_y;
    bsss_pkg::coord_t        vertex_z;
    logic                    end_of_face;
    logic                    end_of_set;

    modport source (output valid, op, center_x, center_y, center_z, vertex_x, vertex_y,
                    vertex_z, end_of_face, end_of_set, input ready);
    modport sink (input valid, op, center_x, center_y, center_z, vertex_x, vertex_y,
                  vertex_z, end_of_face, end_of_set, output ready);
endinterface

FILE: rtl/bsss_result_if.sv
interface bsss_result_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 found;
    logic [bsss_pkg::AXIS_BITS-1:0]       split_axis;
    logic [bsss_pkg::PLANE_BITS-1:0]      split_plane;
    bsss_pkg::count_t                     left_count;
    bsss_pkg::coord_t                     split_origin;
    logic [bsss_pkg::COORD_BITS-1:0]      axis_span;

    modport source (output valid, found, split_axis, split_plane, left_count, split_origin,
                    axis_span, input ready);
    modport sink (input valid, found, split_axis, split_plane, left_count, split_origin,
                  axis_span, output ready);
endinterface

FILE: rtl/bsss_cell.sv
module bsss_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsss_pkg::cell_ctrl_t ctrl,
    input  bsss_pkg::vec3_t      vertex,
    input  logic                 inner,
    input  bsss_pkg::cell_t      from_next,
    output bsss_pkg::cell_t      state
);

    bsss_pkg::cell_t cell_reg;
    bsss_pkg::cell_t cell_next;

    function automatic bsss_pkg::box_t grow(input bsss_pkg::box_t b, input bsss_pkg::vec3_t v);
        bsss_pkg::box_t r;
        r = b;
        if (v.x < b.lo.x) r.lo.x = v.x;
        if (v.y < b.lo.y) r.lo.y = v.y;
        if (v.z < b.lo.z) r.lo.z = v.z;
        if (v.x > b.hi.x) r.hi.x = v.x;
        if (v.y > b.hi.y) r.hi.y = v.y;
        if (v.z > b.hi.z) r.hi.z = v.z;
        return r;
    endfunction

    always_comb
    begin
        cell_next = cell_reg;
        if (ctrl.shift)
        begin
            cell_next = from_next;
        end
        else if (ctrl.upd)
        begin
            if (inner)
            begin
                cell_next.inner = grow(cell_reg.inner, vertex);
                if (ctrl.eof && cell_reg.count != bsss_pkg::COUNT_MAX)
                begin
                    cell_next.count = cell_reg.count + 1'b1;
                end
            end
            else
            begin
                cell_next.outer = grow(cell_reg.outer, vertex);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= bsss_pkg::CELL_RESET;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign state = cell_reg;

endmodule

FILE: rtl/bsss_score.sv
module bsss_score (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   clear,
    input  logic                   feed,
    input  bsss_pkg::cell_t        plane,
    input  bsss_pkg::plane_idx_t   idx,
    input  bsss_pkg::count_t       total,
    output bsss_pkg::best_t        best
);

    typedef logic [bsss_pkg::EXT_BITS-1:0]  ext_t;
    typedef logic [bsss_pkg::PROD_BITS-1:0] prod_t;
    typedef logic [bsss_pkg::SA_BITS-1:0]   sa_t;
    typedef logic [bsss_pkg::TERM_BITS-1:0] term_t;
    typedef logic [bsss_pkg::SCORE_BITS-1:0] score_t;

    function automatic ext_t extent(input bsss_pkg::coord_t lo, input bsss_pkg::coord_t hi);
        logic signed [bsss_pkg::COORD_BITS:0] d;
        d = {hi[bsss_pkg::COORD_BITS-1], hi} - {lo[bsss_pkg::COORD_BITS-1], lo};
        return (hi >= lo) ? d[bsss_pkg::EXT_BITS-1:0] : '0;
    endfunction

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 ok1_reg, ok2_reg, ok3_reg, ok4_reg;
    bsss_pkg::plane_idx_t i1_reg, i2_reg, i3_reg, i4_reg;
    bsss_pkg::count_t     n1_reg, n2_reg, n3_reg, n4_reg;
    bsss_pkg::count_t     m1_reg, m2_reg, m3_reg;
    ext_t                 ei_reg [3];
    ext_t                 eo_reg [3];
    prod_t                pi_reg [3];
    prod_t                po_reg [3];
    sa_t                  sai_reg, sao_reg;
    term_t                ti_reg, to_reg;
    bsss_pkg::best_t      best_reg, best_next;
    score_t               score_best_reg, score_best_next;
    score_t               score;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= feed;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ei_reg[0] <= extent(plane.inner.lo.x, plane.inner.hi.x);
        ei_reg[1] <= extent(plane.inner.lo.y, plane.inner.hi.y);
        ei_reg[2] <= extent(plane.inner.lo.z, plane.inner.hi.z);
        eo_reg[0] <= extent(plane.outer.lo.x, plane.outer.hi.x);
        eo_reg[1] <= extent(plane.outer.lo.y, plane.outer.hi.y);
        eo_reg[2] <= extent(plane.outer.lo.z, plane.outer.hi.z);
        ok1_reg   <= (plane.count != '0) && (plane.count < total);
        n1_reg    <= plane.count;
        m1_reg    <= total - plane.count;
        i1_reg    <= idx;

        pi_reg[0] <= ei_reg[0] * ei_reg[1];
        pi_reg[1] <= ei_reg[1] * ei_reg[2];
        pi_reg[2] <= ei_reg[0] * ei_reg[2];
        po_reg[0] <= eo_reg[0] * eo_reg[1];
        po_reg[1] <= eo_reg[1] * eo_reg[2];
        po_reg[2] <= eo_reg[0] * eo_reg[2];
        ok2_reg   <= ok1_reg;
        n2_reg    <= n1_reg;
        m2_reg    <= m1_reg;
        i2_reg    <= i1_reg;

        sai_reg   <= (sa_t'(pi_reg[0]) + sa_t'(pi_reg[1]) + sa_t'(pi_reg[2])) << 1;
        sao_reg   <= (sa_t'(po_reg[0]) + sa_t'(po_reg[1]) + sa_t'(po_reg[2])) << 1;
        ok3_reg   <= ok2_reg;
        n3_reg    <= n2_reg;
        m3_reg    <= m2_reg;
        i3_reg    <= i2_reg;

        ti_reg    <= term_t'(sai_reg) * term_t'(n3_reg);
        to_reg    <= term_t'(sao_reg) * term_t'(m3_reg);
        ok4_reg   <= ok3_reg;
        n4_reg    <= n3_reg;
        i4_reg    <= i3_reg;
    end

    assign score = score_t'(ti_reg) + score_t'(to_reg);

    always_comb
    begin
        best_next       = best_reg;
        score_best_next = score_best_reg;
        if (clear)
        begin
            best_next       = '0;
            score_best_next = '0;
        end
        else if (v4_reg && ok4_reg && (!best_reg.found || score < score_best_reg))
        begin
            best_next.found = 1'b1;
            best_next.idx   = i4_reg;
            best_next.count = n4_reg;
            score_best_next = score;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg       <= '0;
            score_best_reg <= '0;
        end
        else
        begin
            best_reg       <= best_next;
            score_best_reg <= score_best_next;
        end
    end

    assign best = best_reg;

endmodule

FILE: rtl/binned_sah_split_select_core.sv
// Binned SAH split selector. Center-pass items (op=0) and vertex items (op=1) are taken one
// per cycle while idle; each vertex item updates all 48 plane cells at once. A vertex item
// with end_of_set starts a drain: the cell row shifts its planes one per cycle into a
// five-stage scoring pipeline, and the row is refilled with empty boxes as it shifts. The
// result then goes to the output register, and the next set may start. The input is not
// ready from the end-of-set item until the result has entered the output register.
module binned_sah_split_select_core (
    input  logic   clk,
    input  logic   rst_n,
    bsss_item_if.sink     items,
    bsss_result_if.source results
);

    localparam int NA = bsss_pkg::NUM_AXES;
    localparam int NP = bsss_pkg::NPLANES;
    localparam int CB = bsss_pkg::COORD_BITS;
    localparam int LB = bsss_pkg::LHS_BITS;
    localparam logic signed [LB-1:0] LHS_MUL = LB'(bsss_pkg::PLANES_PER_AXIS + 1);

    bsss_pkg::state_t                  state_reg, state_next;
    logic [bsss_pkg::DRAIN_BITS-1:0]   cnt_reg, cnt_next;
    bsss_pkg::coord_t                  clo_reg [NA];
    bsss_pkg::coord_t                  chi_reg [NA];
    bsss_pkg::count_t                  total_reg;
    bsss_pkg::coord_t                  cin [NA];
    logic [CB-1:0]                     span_w [NA];
    logic signed [LB-1:0]              lhs_w [NA];
    bsss_pkg::cell_t                   cells [NP];
    logic [NP-1:0]                     inner_w;
    bsss_pkg::cell_ctrl_t              ctrl;
    bsss_pkg::vec3_t                   vertex;
    bsss_pkg::best_t                   best;
    logic                              acc, vtx_acc, eos_vtx, load;
    logic [bsss_pkg::AXIS_BITS-1:0]    best_axis;
    logic                              out_valid_reg;
    logic                              found_reg;
    logic [bsss_pkg::AXIS_BITS-1:0]    axis_reg;
    logic [bsss_pkg::PLANE_BITS-1:0]   plane_reg;
    bsss_pkg::count_t                  left_reg;
    bsss_pkg::coord_t                  origin_reg;
    logic [CB-1:0]                     span_reg;

    assign cin[0] = items.center_x;
    assign cin[1] = items.center_y;
    assign cin[2] = items.center_z;
    assign vertex = '{x: items.vertex_x, y: items.vertex_y, z: items.vertex_z};

    assign items.ready = (state_reg == bsss_pkg::ST_IDLE);
    assign acc         = items.valid && items.ready;
    assign vtx_acc     = acc && items.op;
    assign eos_vtx     = vtx_acc && items.end_of_set;
    assign load        = (state_reg == bsss_pkg::ST_FIN) && (!out_valid_reg || results.ready);

    assign ctrl.upd   = vtx_acc;
    assign ctrl.eof   = items.end_of_face;
    assign ctrl.shift = (state_reg == bsss_pkg::ST_DRAIN) && (cnt_reg < NP);

    for (genvar a = 0; a < NA; a++)
    begin : g_axis
        logic signed [CB:0] sd;
        logic signed [CB:0] cd;
        assign sd        = {chi_reg[a][CB-1], chi_reg[a]} - {clo_reg[a][CB-1], clo_reg[a]};
        assign span_w[a] = (chi_reg[a] >= clo_reg[a]) ? sd[CB-1:0] : '0;
        assign cd        = {cin[a][CB-1], cin[a]} - {clo_reg[a][CB-1], clo_reg[a]};
        assign lhs_w[a]  = LB'(cd) * LHS_MUL;
    end

    for (genvar k = 0; k < NP; k++)
    begin : g_cell
        localparam int AX   = k / bsss_pkg::PLANES_PER_AXIS;
        localparam int STEP = k % bsss_pkg::PLANES_PER_AXIS + 1;
        logic signed [LB-1:0] thr;
        bsss_pkg::cell_t nxt;
        assign thr        = $signed(LB'(STEP) * LB'(span_w[AX]));
        assign inner_w[k] = lhs_w[AX] <= thr;
        if (k == NP - 1)
        begin : g_last
            assign nxt = bsss_pkg::CELL_RESET;
        end
        else
        begin : g_mid
            assign nxt = cells[k+1];
        end
        bsss_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .vertex    (vertex),
            .inner     (inner_w[k]),
            .from_next (nxt),
            .state     (cells[k])
        );
    end

    bsss_score u_score (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (eos_vtx),
        .feed  (ctrl.shift),
        .plane (cells[0]),
        .idx   (cnt_reg[bsss_pkg::IDX_BITS-1:0]),
        .total (total_reg),
        .best  (best)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            bsss_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (eos_vtx)
                begin
                    state_next = bsss_pkg::ST_DRAIN;
                end
            end
            bsss_pkg::ST_DRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == bsss_pkg::DRAIN_BITS'(bsss_pkg::DRAIN_LAST))
                begin
                    state_next = bsss_pkg::ST_FIN;
                end
            end
            bsss_pkg::ST_FIN:
            begin
                if (load)
                begin
                    state_next = bsss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bsss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsss_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NA; a++)
            begin
                clo_reg[a] <= bsss_pkg::CMAX;
                chi_reg[a] <= bsss_pkg::CMIN;
            end
            total_reg <= '0;
        end
        else if (load)
        begin
            for (int a = 0; a < NA; a++)
            begin
                clo_reg[a] <= bsss_pkg::CMAX;
                chi_reg[a] <= bsss_pkg::CMIN;
            end
            total_reg <= '0;
        end
        else
        begin
            if (acc && !items.op)
            begin
                for (int a = 0; a < NA; a++)
                begin
                    if (cin[a] < clo_reg[a]) clo_reg[a] <= cin[a];
                    if (cin[a] > chi_reg[a]) chi_reg[a] <= cin[a];
                end
            end
            if (vtx_acc && items.end_of_face && total_reg != bsss_pkg::COUNT_MAX)
            begin
                total_reg <= total_reg + 1'b1;
            end
        end
    end

    assign best_axis = bsss_pkg::AXIS_BITS'(best.idx / bsss_pkg::PLANES_PER_AXIS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg  <= best.found;
            axis_reg   <= best.found ? best_axis : '0;
            plane_reg  <= best.found ?
                          bsss_pkg::PLANE_BITS'(best.idx % bsss_pkg::PLANES_PER_AXIS) : '0;
            left_reg   <= best.found ? best.count : '0;
            origin_reg <= best.found ? clo_reg[best_axis] : '0;
            span_reg   <= best.found ? span_w[best_axis] : '0;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.found        = found_reg;
    assign results.split_axis   = axis_reg;
    assign results.split_plane  = plane_reg;
    assign results.left_count   = left_reg;
    assign results.split_origin = origin_reg;
    assign results.axis_span    = span_reg;

    a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bsss_pkg::ST_FIN))
        else $error("Result appeared without a finished drain.");

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (axis_reg == '0 && plane_reg == '0 && left_reg == '0))
        else $error("Empty result carries nonzero fields.");

    a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (left_reg != '0 && axis_reg != 2'd3))
        else $error("Chosen split is malformed.");

    a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bsss_pkg::ST_DRAIN &&
         cnt_reg != bsss_pkg::DRAIN_BITS'(bsss_pkg::DRAIN_LAST))
        |=> (state_reg == bsss_pkg::ST_DRAIN && cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("Drain counter skipped.");

endmodule
